/* sv/ctd_pkg.sv */
// ----------------------------------------------------------------------------
// ctd_pkg: shared types and constants of the chunked transfer decoder
// Phase codes, status codes, the result record and character classifiers.
// ----------------------------------------------------------------------------
package ctd_pkg;

    localparam int unsigned CFG_W = 24;

    localparam logic [CFG_W-1:0] MAX_CHUNK_RESET = 24'd4096;

    localparam logic [2:0] ST_NONE    = 3'd0;
    localparam logic [2:0] ST_DONE    = 3'd1;
    localparam logic [2:0] ST_SYNTAX  = 3'd2;
    localparam logic [2:0] ST_TOOLONG = 3'd3;
    localparam logic [2:0] ST_TRUNC   = 3'd4;

    localparam logic [1:0] PH_SIZE = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_TAIL = 2'd2;
    localparam logic [1:0] PH_IDLE = 2'd3;

    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_VT   = 8'h0B;
    localparam logic [7:0] CH_FF   = 8'h0C;
    localparam logic [7:0] CH_SP   = 8'h20;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic [2:0] status;
    } result_t;

    // Bit 4 flags a hex digit, bits 3:0 carry its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_VT) ||
               (c == CH_FF) || (c == CH_CR);
    endfunction

endpackage

/* sv/ctd_out_reg.sv */
// ----------------------------------------------------------------------------
// ctd_out_reg: result register of the chunked transfer decoder
// Holds one result transfer and frees itself in the cycle it is taken.
// ----------------------------------------------------------------------------
module ctd_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  ctd_pkg::result_t load_data,
    output logic             free,
    output logic             m_valid,
    input  logic             m_ready,
    output ctd_pkg::result_t m_data
);
    import ctd_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign free    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (free && load) begin
            data_reg <= load_data;
        end
    end

endmodule

/* sv/chunked_transfer_decoder_top.sv */
// ----------------------------------------------------------------------------
// chunked_transfer_decoder_top: HTTP chunked body decoder
// Takes one raw byte of a chunked body per transfer and passes the payload
// bytes on, one per result transfer, followed by a single status transfer
// (body complete, invalid syntax, chunk too long or truncated input), after
// which every further input transfer is taken and dropped until reset. The
// decoder sustains one input byte per clock: each byte updates the parse
// state in one registered step, and the result register lets a new byte in
// while the previous result is still being taken, so s_ready only drops when
// the result register is full and m_ready is low. cfg_we writes the maximum
// chunk size; it should only change while the decoder is idle.
// ----------------------------------------------------------------------------
module chunked_transfer_decoder_top #(
    parameter int unsigned SIZE_BITS = 24
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [ctd_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_in_byte,
    input  logic                      s_in_end,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [7:0]                m_out_byte,
    output logic                      m_is_data,
    output logic [2:0]                m_status
);
    import ctd_pkg::*;

    localparam int unsigned ACC_W = SIZE_BITS + 1;
    localparam int unsigned MUL_W = SIZE_BITS + 5;
    localparam int unsigned CMP_W = (ACC_W > CFG_W) ? ACC_W : CFG_W;
    localparam logic [MUL_W-1:0] CAP = MUL_W'(1) << SIZE_BITS;

    logic [CFG_W-1:0]     max_reg;
    logic [1:0]           phase_reg, phase_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [SIZE_BITS-1:0] rem_reg, rem_next;
    logic                 seen_reg, seen_next;
    logic                 closed_reg, closed_next;
    logic                 nonempty_reg, nonempty_next;
    logic                 cr_reg, cr_next;

    logic       accept;
    logic       emit;
    result_t    res;
    result_t    m_data;
    logic [4:0] hex;
    logic [MUL_W-1:0] acc_mul;
    logic       too_long;

    assign accept = s_valid && s_ready;
    assign hex    = hex_digit(s_in_byte);
    assign acc_mul = {acc_reg, 4'b0000} + MUL_W'(hex[3:0]);
    assign too_long = acc_reg[SIZE_BITS] ||
                      (CMP_W'(acc_reg) > CMP_W'(max_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= MAX_CHUNK_RESET;
        end else if (cfg_we) begin
            max_reg <= cfg_wdata;
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        rem_next      = rem_reg;
        seen_next     = seen_reg;
        closed_next   = closed_reg;
        nonempty_next = nonempty_reg;
        cr_next       = cr_reg;
        emit          = 1'b0;
        res           = '0;
        if (accept && phase_reg != PH_IDLE) begin
            if (s_in_end) begin
                emit       = 1'b1;
                res.status = ST_TRUNC;
                phase_next = PH_IDLE;
            end else begin
                unique case (phase_reg)
                    PH_SIZE: begin
                        if (s_in_byte == CH_LF) begin
                            if (!seen_reg) begin
                                emit       = 1'b1;
                                res.status = ST_SYNTAX;
                                phase_next = PH_IDLE;
                            end else if (too_long) begin
                                emit       = 1'b1;
                                res.status = ST_TOOLONG;
                                phase_next = PH_IDLE;
                            end else begin
                                rem_next      = acc_reg[SIZE_BITS-1:0];
                                seen_next     = 1'b0;
                                closed_next   = 1'b0;
                                nonempty_next = 1'b0;
                                cr_next       = 1'b0;
                                phase_next    = (acc_reg == '0) ? PH_TAIL : PH_DATA;
                            end
                        end else if (!closed_reg) begin
                            if (hex[4]) begin
                                // The accumulator sticks one above the largest size.
                                acc_next  = (acc_mul > CAP) ? ACC_W'(CAP)
                                                            : acc_mul[ACC_W-1:0];
                                seen_next = 1'b1;
                            end else if (!(is_blank(s_in_byte) && !seen_reg)) begin
                                closed_next = 1'b1;
                            end
                        end
                    end
                    PH_DATA: begin
                        emit         = 1'b1;
                        res.out_byte = s_in_byte;
                        res.is_data  = 1'b1;
                        res.status   = ST_NONE;
                        rem_next     = rem_reg - SIZE_BITS'(1);
                        if (rem_reg == SIZE_BITS'(1)) begin
                            seen_next     = 1'b0;
                            closed_next   = 1'b0;
                            nonempty_next = 1'b0;
                            cr_next       = 1'b0;
                            phase_next    = PH_TAIL;
                        end
                    end
                    PH_TAIL: begin
                        if (s_in_byte == CH_LF) begin
                            if (nonempty_reg) begin
                                emit       = 1'b1;
                                res.status = ST_SYNTAX;
                                phase_next = PH_IDLE;
                            end else if (acc_reg == '0) begin
                                emit       = 1'b1;
                                res.status = ST_DONE;
                                phase_next = PH_IDLE;
                            end else begin
                                acc_next      = '0;
                                rem_next      = '0;
                                seen_next     = 1'b0;
                                closed_next   = 1'b0;
                                nonempty_next = 1'b0;
                                cr_next       = 1'b0;
                                phase_next    = PH_SIZE;
                            end
                        end else begin
                            // Only a single CR right before the LF is tolerated.
                            if (s_in_byte == CH_CR) begin
                                cr_next = 1'b1;
                                if (cr_reg) begin
                                    nonempty_next = 1'b1;
                                end
                            end else begin
                                cr_next       = 1'b0;
                                nonempty_next = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SIZE;
            acc_reg      <= '0;
            rem_reg      <= '0;
            seen_reg     <= 1'b0;
            closed_reg   <= 1'b0;
            nonempty_reg <= 1'b0;
            cr_reg       <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            acc_reg      <= acc_next;
            rem_reg      <= rem_next;
            seen_reg     <= seen_next;
            closed_reg   <= closed_next;
            nonempty_reg <= nonempty_next;
            cr_reg       <= cr_next;
        end
    end

    ctd_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (emit),
        .load_data (res),
        .free      (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    assign m_out_byte = m_data.out_byte;
    assign m_is_data  = m_data.is_data;
    assign m_status   = m_data.status;

    a_data_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> rem_reg != '0)
        else $error("data phase entered with no bytes left");

    a_idle_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE |=> phase_reg == PH_IDLE)
        else $error("decoder left idle without reset");

    a_status_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_data == (m_status == ST_NONE)))
        else $error("status code does not match transfer kind");

    a_acc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_reg[SIZE_BITS] |-> acc_reg[SIZE_BITS-1:0] == '0)
        else $error("size accumulator beyond saturation value");

endmodule
